/* design/assert_macros.svh */
// Assertion macros shared by the servo pulse ramp generator RTL.
// Each macro expands to one labeled concurrent assertion that reports through $error.
// The enclosing module must provide the clk and rst_n signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, and switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clk edge, including the cycles spent in reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/sprg_pkg.sv */
// Package for the servo pulse ramp generator: widths, reset values, command codes,
// the register index codes, the constant-divide reciprocal and the shared structs.
// It has no dependencies.
`timescale 1ns / 1ps

package sprg_pkg;

    localparam int CNT_W     = 16;
    localparam int WAIT_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_SEG   = 3;

    localparam logic [CNT_W-1:0] PERIOD_RESET     = 16'd20000;
    localparam logic [CNT_W-1:0] STEP_DELAY_RESET = 16'd500;

    // Multiplying by ceil(2^19/10) and shifting right by 19 gives an exact
    // divide by ten for every 16-bit value. The same product shifted by 18 is
    // an exact divide by five.
    localparam int                    RECIP_W  = 17;
    localparam logic [RECIP_W-1:0]    RECIP_10 = 17'd52429;
    localparam int                    SHIFT_10 = 19;
    localparam int                    SHIFT_5  = 18;
    localparam int                    PROD_W   = CNT_W + RECIP_W;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_GO    = 2'd1,
        CMD_PLACE = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD     = 2'd0,
        CFG_STEP_DELAY = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [CNT_W-1:0] pos;
    } sprg_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] step_delay;
    } sprg_cfg_t;

endpackage

/* design/sprg_ramp_core.sv */
// Ramp state and its combinational update for the servo pulse ramp generator.
// Depends on sprg_pkg for widths, command codes, the divide reciprocal and structs.
`timescale 1ns / 1ps

module sprg_ramp_core
    import sprg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  sprg_item_t       item,
    input  sprg_cfg_t        cfg,
    output logic [CNT_W-1:0] compare_value,
    output logic             busy
);

    logic [CNT_W-1:0]  compare_reg, compare_next;
    logic [CNT_W-1:0]  ramp_pos_reg, ramp_pos_next;
    logic [CNT_W-1:0]  ramp_end_reg, ramp_end_next;
    logic [CNT_W-1:0]  bound_reg [NUM_SEG];
    logic [CNT_W-1:0]  bound_next [NUM_SEG];
    logic              ramp_up_reg, ramp_up_next;
    logic [WAIT_W-1:0] wait_cnt_reg, wait_cnt_next;
    logic              active_reg, active_next;

    logic [CNT_W-1:0]  end_val;
    logic              go_up;
    logic [CNT_W-1:0]  span;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  dist_div [NUM_SEG];
    logic [CNT_W-1:0]  pos_step;
    logic [NUM_SEG-1:0] in_seg;
    logic [WAIT_W-1:0] delay_x1, delay_x2, delay_x3, delay_x15;
    logic [WAIT_W-1:0] wait_step;
    logic [WAIT_W-1:0] wait_dec;

    always_comb
    begin
        // End compare value, saturated at zero.
        end_val = (cfg.period > item.pos) ? (cfg.period - item.pos) : '0;
        go_up   = compare_reg < end_val;
        span    = go_up ? (end_val - compare_reg) : (compare_reg - end_val);

        prod        = PROD_W'(span) * PROD_W'(RECIP_10);
        dist_div[0] = CNT_W'(prod >> SHIFT_10);
        dist_div[1] = CNT_W'(prod >> SHIFT_5);
        dist_div[2] = span >> 1;

        for (int i = 0; i < NUM_SEG; i++)
        begin
            bound_next[i] = go_up ? (compare_reg + dist_div[i])
                                  : (compare_reg - dist_div[i]);
        end

        delay_x1  = WAIT_W'(cfg.step_delay);
        delay_x2  = WAIT_W'({cfg.step_delay, 1'b0});
        delay_x3  = delay_x1 + delay_x2;
        delay_x15 = delay_x3 >> 1;

        // Wait for the position that the next ramp step writes.
        pos_step = ramp_up_reg ? (ramp_pos_reg + 16'd1) : (ramp_pos_reg - 16'd1);
        for (int i = 0; i < NUM_SEG; i++)
        begin
            in_seg[i] = ramp_up_reg ? (pos_step <= bound_reg[i])
                                    : (pos_step >= bound_reg[i]);
        end
        if (in_seg[0])
            wait_step = delay_x3;
        else if (in_seg[1])
            wait_step = delay_x2;
        else if (in_seg[2])
            wait_step = delay_x15;
        else
            wait_step = delay_x1;

        wait_dec = (wait_cnt_reg != '0) ? (wait_cnt_reg - 18'd1) : wait_cnt_reg;

        compare_next  = compare_reg;
        ramp_pos_next = ramp_pos_reg;
        ramp_end_next = ramp_end_reg;
        ramp_up_next  = ramp_up_reg;
        wait_cnt_next = wait_cnt_reg;
        active_next   = active_reg;

        if (step_en)
        begin
            case (cmd_t'(item.cmd))
                CMD_PLACE:
                begin
                    compare_next  = end_val;
                    active_next   = 1'b0;
                    wait_cnt_next = '0;
                end
                CMD_GO:
                begin
                    if (!active_reg)
                    begin
                        ramp_end_next = end_val;
                        ramp_pos_next = compare_reg;
                        ramp_up_next  = go_up;
                        // The start position always lies in the first tenth.
                        wait_cnt_next = delay_x3;
                        active_next   = 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    if (active_reg)
                    begin
                        wait_cnt_next = wait_dec;
                        if (wait_dec == '0)
                        begin
                            compare_next = ramp_pos_reg;
                            if (ramp_pos_reg == ramp_end_reg)
                            begin
                                active_next = 1'b0;
                            end
                            else
                            begin
                                ramp_pos_next = pos_step;
                                wait_cnt_next = wait_step;
                            end
                        end
                    end
                end
                default:
                begin
                    compare_next = compare_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg  <= PERIOD_RESET;
            ramp_pos_reg <= '0;
            ramp_end_reg <= '0;
            ramp_up_reg  <= 1'b0;
            wait_cnt_reg <= '0;
            active_reg   <= 1'b0;
            for (int i = 0; i < NUM_SEG; i++)
            begin
                bound_reg[i] <= '0;
            end
        end
        else
        begin
            compare_reg  <= compare_next;
            ramp_pos_reg <= ramp_pos_next;
            ramp_end_reg <= ramp_end_next;
            ramp_up_reg  <= ramp_up_next;
            wait_cnt_reg <= wait_cnt_next;
            active_reg   <= active_next;
            if (step_en && (cmd_t'(item.cmd) == CMD_GO) && !active_reg)
            begin
                for (int i = 0; i < NUM_SEG; i++)
                begin
                    bound_reg[i] <= bound_next[i];
                end
            end
        end
    end

    assign compare_value = compare_reg;
    assign busy          = active_reg;

endmodule

/* design/servo_pulse_ramp_generator_top.sv */
// Top level of the servo pulse ramp generator: input stage, configuration registers,
// output handshake and assertions. Depends on sprg_pkg, sprg_ramp_core and
// assert_macros.svh.
//
// Usage. Each input beat carries a cmd and a target_position. A tick beat (one per
// microsecond) advances a running ramp, a go beat starts a ramp from the present
// compare value toward period minus target_position, and a place beat sets the
// compare value at once and cancels any ramp. Every input beat, including an
// ignored go or the unused command code, yields exactly one output beat that
// carries the compare value and the busy flag as they stand after that beat.
// Input beats are captured in an input register; the ramp core then updates its
// state, and that state register is the output register. An accepted beat passes
// through the input register and then the core's state register, and one beat is
// taken every cycle while the receiver keeps stall low. The core's update path is
// combinational: a subtract, one 16 by 17 constant multiply for the segment
// bounds, and an add.
// When the receiver stalls, the output beat holds, the captured input beat waits in
// the input register, and in_stall rises so no further input is taken.
// The configuration port is always ready; period and step_delay are written by index
// and should only change while no beat is in flight.
// Reset clears the input and output stages, loads period 20000 and step_delay 500,
// and leaves the compare value at 20000 with no ramp running.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module servo_pulse_ramp_generator_top
    import sprg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           cmd,
    input  logic [CNT_W-1:0]     target_position,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CNT_W-1:0]     compare_value,
    output logic                 busy_res,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    // Input stage: holds one accepted beat until the output slot is free.
    logic       s1_valid_reg, s1_valid_next;
    sprg_item_t s1_item_reg;

    logic out_valid_reg, out_valid_next;

    logic [CNT_W-1:0] period_reg;
    logic [CNT_W-1:0] step_delay_reg;

    logic       in_take;
    logic       out_free;
    logic       step_en;
    sprg_cfg_t  cfg;

    // The output slot can take a new beat when it is empty or is being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign step_en  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (step_en)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step_en)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.cmd <= cmd;
            s1_item_reg.pos <= target_position;
        end
    end

    // Configuration registers; writes to an index beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            step_delay_reg <= STEP_DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PERIOD:     period_reg     <= cfg_data;
                CFG_STEP_DELAY: step_delay_reg <= cfg_data;
                default:        period_reg     <= period_reg;
            endcase
        end
    end

    assign cfg.period     = period_reg;
    assign cfg.step_delay = step_delay_reg;

    sprg_ramp_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .item          (s1_item_reg),
        .cfg           (cfg),
        .compare_value (compare_value),
        .busy          (busy_res)
    );

    assign out_valid = out_valid_reg;

    // A captured beat is never dropped while the output is blocked.
    `ASSERT_CLK(a_s1_hold, (s1_valid_reg && !out_free) |=> s1_valid_reg, "input beat lost while output blocked")

    // The ramp state only moves on a beat that enters the output slot.
    `ASSERT_CLK(a_busy_fall_on_step, $fell(busy_res) |-> $past(step_en), "busy fell without a beat")

    // While a ramp keeps running, each beat moves the compare value by at most one count.
    `ASSERT_CLK(a_ramp_one_count, ($past(busy_res) && busy_res) |-> ((compare_value == $past(compare_value)) || (compare_value == $past(compare_value) + 16'd1) || (compare_value == $past(compare_value) - 16'd1)), "ramp moved by more than one count")

endmodule
